[hdl/mofb_pkg.sv]
// mofb_pkg: shared types and constants for the framebuffer engine
// no dependencies
package mofb_pkg;
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PIXEL   = 2'd1,
    OP_GLYPH   = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  localparam logic [7:0] PAGE_CMD   = 8'hB0;
  localparam logic [7:0] COL_LO_CMD = 8'h00;
  localparam logic [7:0] COL_HI_CMD = 8'h10;
  localparam logic [7:0] DATA_PFX   = 8'h40;

  // queued command from front to back
  typedef struct packed {
    op_t         op;
    logic [11:0] x0;
    logic [11:0] y0;
    logic        pixel_on;
    logic [39:0] glyph_bits;
    logic [11:0] clip_lo;
    logic [11:0] clip_hi;
    logic [2:0]  page;
  } cmd_t;
endpackage

[hdl/mofb_front.sv]
// mofb_front: accepts input beats, resolves glyph origin from the text cursor
// depends on mofb_pkg
module mofb_front #(
  parameter int GLYPH_ADVANCE = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          op,
  input  logic [10:0]         pos_x,
  input  logic [10:0]         pos_y,
  input  logic                pixel_on,
  input  logic [39:0]         glyph_bits,
  input  logic                use_cursor,
  input  logic [10:0]         clip_min,
  input  logic [10:0]         clip_max,
  input  logic [2:0]          page_sel,
  output logic                q_valid,
  input  logic                q_ready,
  output mofb_pkg::cmd_t      q_cmd
);
  import mofb_pkg::*;
  logic [10:0] cur_r, cur_nxt, row_r, row_nxt;
  logic [10:0] gx, gy;
  logic        fire;

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign fire      = in_tvalid && q_ready;

  always_comb begin
    gx = use_cursor ? (cur_r + 11'(GLYPH_ADVANCE)) : pos_x;
    gy = use_cursor ? row_r : pos_y;
    cur_nxt = cur_r;
    row_nxt = row_r;
    if (fire && op_t'(op) == OP_GLYPH) begin
      cur_nxt = gx;
      row_nxt = gy;
    end
    q_cmd.op         = op_t'(op);
    q_cmd.x0         = (op_t'(op) == OP_GLYPH) ? {gx[10], gx} : {pos_x[10], pos_x};
    q_cmd.y0         = (op_t'(op) == OP_GLYPH) ? {gy[10], gy} : {pos_y[10], pos_y};
    q_cmd.pixel_on   = pixel_on;
    q_cmd.glyph_bits = glyph_bits;
    q_cmd.clip_lo    = {clip_min[10], clip_min};
    q_cmd.clip_hi    = {clip_max[10], clip_max};
    q_cmd.page       = page_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      row_r <= '0;
    end else begin
      cur_r <= cur_nxt;
      row_r <= row_nxt;
    end
  end
endmodule

[hdl/mofb_queue.sv]
// mofb_queue: two-entry command queue between front and back
// depends on mofb_pkg
module mofb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mofb_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output mofb_pkg::cmd_t rd_cmd
);
  import mofb_pkg::*;
  cmd_t        mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_cmd   = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

[hdl/mofb_back.sv]
// mofb_back: executes commands on the page store and streams refresh words
// depends on mofb_pkg
module mofb_back #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_COLUMNS = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mofb_pkg::cmd_t cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_data,
  output logic           out_kind,
  output logic           out_last
);
  import mofb_pkg::*;
  localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH  = SCREEN_WIDTH * PAGES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(SCREEN_WIDTH + 1);
  localparam int WPP    = (SCREEN_WIDTH + 7) / 8;
  localparam int GC     = (GLYPH_COLUMNS < 8) ? GLYPH_COLUMNS : 8;
  localparam int GCW    = $clog2(GC + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLR   = 7'b0000010,
    S_RD    = 7'b0000100,
    S_WR    = 7'b0001000,
    S_HDR   = 7'b0010000,
    S_FETCH = 7'b0100000,
    S_SEND  = 7'b1000000
  } st_t;

  st_t         st_r, st_nxt;
  cmd_t        c_r, c_nxt;
  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata_r;
  logic [AW-1:0] ca_r, ca_nxt;
  logic [GCW-1:0] gi_r, gi_nxt;
  logic        part_r, part_nxt;
  logic [3:0]  bi_r, bi_nxt;
  logic [$clog2(WPP+1)-1:0] wi_r, wi_nxt;
  logic [63:0] word_r, word_nxt;
  logic        ov_r, ov_nxt, ok_r, ok_nxt, ol_r, ol_nxt;
  logic [63:0] od_r, od_nxt;

  logic [11:0] cx, ry;
  logic [7:0]  colb, shifted, wbyte;
  logic        col_ok, do_wr, tgt_ok;
  logic [AW-1:0] wa, ra, addr;
  logic        rd_en;
  logic [12:0] rowbase;
  logic [CW:0] ccol;

  assign cmd_ready  = (st_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_data   = od_r;
  assign out_kind   = ok_r;
  assign out_last   = ol_r;

  // column and row of the glyph slice / pixel, row split into page part, store address and target check
  always_comb begin
    cx      = c_r.x0 + 12'(gi_r);
    ry      = c_r.y0 + (part_r ? 12'd8 : 12'd0);
    colb    = 8'(c_r.glyph_bits >> (8 * gi_r));
    col_ok  = ($signed(cx) >= $signed(c_r.clip_lo)) && ($signed(cx) <= $signed(c_r.clip_hi));
    rowbase = {ry[11], ry} - 13'({10'd0, ry[2:0]});
    ccol    = (CW + 1)'(wi_r) * (CW + 1)'(8) + (CW + 1)'(bi_r);
    addr    = AW'(32'(rowbase[12:3]) * SCREEN_WIDTH + 32'(cx));
    if (c_r.op == OP_PIXEL)
      tgt_ok = ($signed(cx) >= 0) && ($signed(cx) < SCREEN_WIDTH) &&
               ($signed(ry) >= 0) && ($signed(ry) < SCREEN_HEIGHT);
    else
      tgt_ok = ($signed(cx) >= 0) && ($signed(cx) < SCREEN_WIDTH) && col_ok &&
               ($signed(rowbase) >= 0) && ($signed(rowbase) < PAGES * 8);
  end

  always_comb begin
    st_nxt = st_r; c_nxt = c_r; ca_nxt = ca_r; gi_nxt = gi_r; part_nxt = part_r;
    bi_nxt = bi_r; wi_nxt = wi_r; word_nxt = word_r;
    ov_nxt = ov_r; ok_nxt = ok_r; ol_nxt = ol_r; od_nxt = od_r;
    do_wr = 1'b0; wa = '0; wbyte = '0; rd_en = 1'b0; ra = '0; shifted = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          c_nxt = cmd; gi_nxt = '0; part_nxt = 1'b0; wi_nxt = '0; bi_nxt = '0;
          case (cmd.op)
            OP_CLEAR: begin
              ca_nxt = '0;
              st_nxt = S_CLR;
            end
            OP_REFRESH: st_nxt = S_HDR;
            OP_GLYPH:   st_nxt = S_RD;
            default:    st_nxt = S_RD;
          endcase
        end
      end
      S_CLR: begin
        // one store byte zeroed per cycle
        do_wr  = 1'b1;
        wa     = ca_r;
        ca_nxt = ca_r + 1'b1;
        if (ca_r == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_RD: begin
        // read the target byte when it lies on the screen (and, for a glyph, inside the clip window)
        if (tgt_ok) begin
          rd_en = 1'b1;
          ra    = addr;
        end
        st_nxt = S_WR;
      end
      S_WR: begin
        wa = addr;
        if (c_r.op == OP_PIXEL) begin
          shifted = 8'd1 << ry[2:0];
          if (tgt_ok) begin
            do_wr = 1'b1;
            wbyte = c_r.pixel_on ? (rdata_r | shifted) : (rdata_r & ~shifted);
          end
          st_nxt = S_IDLE;
        end else begin
          // lower page part gets colb << off, upper part colb >> (8-off)
          shifted = part_r ? 8'({8'd0, colb} >> (4'd8 - {1'b0, ry[2:0]})) : (colb << ry[2:0]);
          if (part_r && ry[2:0] == 3'd0) shifted = '0;
          if (tgt_ok) begin
            if (SCREEN_HEIGHT % 8 != 0 && (PAGES * 8 - SCREEN_HEIGHT) > 0 &&
                $signed(rowbase) == (PAGES - 1) * 8)
              shifted = shifted & 8'((9'd1 << (SCREEN_HEIGHT % 8)) - 9'd1);
            do_wr = shifted != 0;
            wbyte = rdata_r | shifted;
          end
          if (part_r) begin
            part_nxt = 1'b0;
            if (gi_r == GCW'(GC - 1)) st_nxt = S_IDLE;
            else begin gi_nxt = gi_r + 1'b1; st_nxt = S_RD; end
          end else begin
            part_nxt = 1'b1; st_nxt = S_RD;
          end
          if (GC == 0) st_nxt = S_IDLE;
        end
      end
      S_HDR: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1; ok_nxt = 1'b0; ol_nxt = 1'b0;
          od_nxt = {32'd0, DATA_PFX, COL_HI_CMD, COL_LO_CMD, PAGE_CMD + {5'd0, c_r.page}};
          st_nxt = S_FETCH; bi_nxt = '0; word_nxt = '0;
        end
      end
      S_FETCH: begin
        // one byte a cycle, read data lands next cycle
        if (bi_r != 4'd0) begin
          if (32'(c_r.page) < PAGES && 32'(ccol - 1'b1) < SCREEN_WIDTH)
            word_nxt[8 * (bi_r - 1) +: 8] = rdata_r;
        end
        if (bi_r == 4'd8) st_nxt = S_SEND;
        else begin
          rd_en  = 1'b1;
          ra     = AW'(32'(c_r.page) * SCREEN_WIDTH + 32'(ccol));
          bi_nxt = bi_r + 1'b1;
        end
      end
      S_SEND: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1; ok_nxt = 1'b1; od_nxt = word_r;
          ol_nxt = (wi_r == ($clog2(WPP+1))'(WPP - 1));
          word_nxt = '0; bi_nxt = '0;
          if (wi_r == ($clog2(WPP+1))'(WPP - 1)) st_nxt = S_IDLE;
          else begin wi_nxt = wi_r + 1'b1; st_nxt = S_FETCH; end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // single-port page store, registered read
  always_ff @(posedge clk) begin
    if (do_wr) mem[wa] <= wbyte;
    if (rd_en) rdata_r <= mem[ra];
    else if (st_r == S_RD) rdata_r <= '0;
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt; word_r <= word_nxt; od_r <= od_nxt; ok_r <= ok_nxt; ol_r <= ol_nxt;
    if (!rst_n) begin
      st_r <= S_CLR; ca_r <= '0; ov_r <= 1'b0; gi_r <= '0; part_r <= 1'b0; bi_r <= '0;
      wi_r <= '0;
    end else begin
      st_r <= st_nxt; ca_r <= ca_nxt; ov_r <= ov_nxt; gi_r <= gi_nxt; part_r <= part_nxt;
      bi_r <= bi_nxt; wi_r <= wi_nxt;
    end
  end
endmodule

[hdl/mono_oled_framebuffer_engine.sv]
// mono_oled_framebuffer_engine: top level, front, queue and back
// depends on mofb_pkg, mofb_front, mofb_queue, mofb_back
//
// Page-layout monochrome framebuffer. The store is cleared by a pass that
// zeroes one byte a cycle, SCREEN_WIDTH times the page count bytes (1024 at
// the default size), once after reset and again for every clear; input beats
// still fill the two-entry queue meanwhile. A pixel write steps through
// accept, read and write; a glyph, after the accept, takes each column as two
// page slices of a read and a write each; and a refresh sends one header beat
// then, per data word, eight single-byte reads from the registered store port
// followed by the send. The single read/write store port serialises these
// steps; the back end takes its next command only once the last refresh word
// has been accepted.
module mono_oled_framebuffer_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_COLUMNS = 5,
  parameter int GLYPH_ADVANCE = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[10:0] pos_y[21:11] pixel_on[22] glyph_bits[62:23] use_cursor[63]
  // clip_min[74:64] clip_max[85:75] page_sel[88:86]
  input  logic [95:0]  in_tdata,
  // operation[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // word_data[63:0]
  output logic [63:0]  out_tdata,
  // word_kind[0]
  output logic         out_tuser,
  output logic         out_tlast
);
  import mofb_pkg::*;
  logic qi_v, qi_r, qo_v, qo_r;
  cmd_t qi_c, qo_c;

  mofb_front #(.GLYPH_ADVANCE(GLYPH_ADVANCE)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .op(in_tuser), .pos_x(in_tdata[10:0]), .pos_y(in_tdata[21:11]),
    .pixel_on(in_tdata[22]), .glyph_bits(in_tdata[62:23]), .use_cursor(in_tdata[63]),
    .clip_min(in_tdata[74:64]), .clip_max(in_tdata[85:75]), .page_sel(in_tdata[88:86]),
    .q_valid(qi_v), .q_ready(qi_r), .q_cmd(qi_c)
  );

  mofb_queue u_queue (
    .clk, .rst_n, .wr_valid(qi_v), .wr_ready(qi_r), .wr_cmd(qi_c),
    .rd_valid(qo_v), .rd_ready(qo_r), .rd_cmd(qo_c)
  );

  mofb_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .GLYPH_COLUMNS(GLYPH_COLUMNS)
  ) u_back (
    .clk, .rst_n, .cmd_valid(qo_v), .cmd_ready(qo_r), .cmd(qo_c),
    .out_tvalid, .out_tready, .out_data(out_tdata), .out_kind(out_tuser),
    .out_last(out_tlast)
  );
endmodule

[test/mono_oled_framebuffer_engine_test.sv]
// mono_oled_framebuffer_engine_test: self-checking bench for the framebuffer engine
// depends on mofb_pkg and mono_oled_framebuffer_engine
// a scoreboard keeps a shadow framebuffer and queues the words each refresh should send
module mono_oled_framebuffer_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mofb_pkg::*;

  localparam int SW = 128;
  localparam int SH = 64;
  localparam int GCOLS = 5;
  localparam int GADV = 6;
  localparam int LIMIT = 900000;

  typedef struct {
    logic        kind;
    logic [63:0] data;
    logic        last;
  } fb_word_t;

  class fb_scoreboard;
    logic [7:0] shadow [SW*8];
    int cursor_x;
    int cursor_y;
    fb_word_t pending [$];
    int errors;

    function new();
      clear_shadow();
      cursor_x = 0;
      cursor_y = 0;
      errors = 0;
    endfunction

    function void clear_shadow();
      for (int i = 0; i < SW*8; i++) shadow[i] = 8'h00;
    endfunction

    function int sx11(logic [10:0] v);
      return $signed(v);
    endfunction

    function void put_pixel(int x, int y, bit on);
      int idx;
      if (x < 0 || y < 0 || x >= SW || y >= SH) return;
      idx = x + (y / 8) * SW;
      shadow[idx][y % 8] = on;
    endfunction

    // item layout: operation[1:0], then the tdata fields from bit 2 up
    function void note_input(logic [97:0] d);
      op_t op;
      int x0, y0, lo, hi;
      logic [10:0] adv;
      logic [7:0] colb;
      logic [2:0] pg;
      fb_word_t w;
      op = op_t'(d[1:0]);
      case (op)
        OP_CLEAR: clear_shadow();
        OP_PIXEL: put_pixel(sx11(d[12:2]), sx11(d[23:13]), d[24]);
        OP_GLYPH: begin
          if (d[65]) begin
            adv = 11'(cursor_x + GADV);
            x0 = sx11(adv);
            y0 = cursor_y;
          end else begin
            x0 = sx11(d[12:2]);
            y0 = sx11(d[23:13]);
          end
          lo = sx11(d[76:66]);
          hi = sx11(d[87:77]);
          for (int i = 0; i < GCOLS; i++) begin
            colb = d[25 + 8*i +: 8];
            if (x0 + i < lo || x0 + i > hi) continue;
            for (int j = 0; j < 8; j++)
              if (colb[j]) put_pixel(x0 + i, y0 + j, 1'b1);
          end
          cursor_x = x0;
          cursor_y = y0;
        end
        OP_REFRESH: begin
          pg = d[90:88];
          w.kind = 1'b0;
          w.last = 1'b0;
          w.data = {32'h0, DATA_PFX, COL_HI_CMD, COL_LO_CMD, PAGE_CMD + 8'(pg)};
          pending.push_back(w);
          for (int k = 0; k < SW/8; k++) begin
            w.kind = 1'b1;
            w.last = (k == SW/8 - 1);
            w.data = '0;
            for (int b = 0; b < 8; b++)
              if (pg < SH/8) w.data[8*b +: 8] = shadow[pg*SW + k*8 + b];
            pending.push_back(w);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic kind, logic [63:0] data, logic last);
      fb_word_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: expected none, actual kind %0b data %h last %0b",
                 $time, kind, data, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind !== kind || e.data !== data || e.last !== last) begin
        $display("%0t mismatch: expected %0b %h %0b, actual %0b %h %0b",
                 $time, e.kind, e.data, e.last, kind, data, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  fb_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int cycles = 0;

  always #10 clk = ~clk;

  mono_oled_framebuffer_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("mono_oled_framebuffer_engine_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tuser, out_tdata, out_tlast);
    if (hold_recv) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [97:0] pack_cmd(op_t op, logic [10:0] x, logic [10:0] y,
      logic on, logic [39:0] g, logic uc, logic [10:0] lo, logic [10:0] hi, logic [2:0] pg);
    return {7'b0, pg, hi, lo, uc, g, on, y, x, op};
  endfunction

  task automatic push_item(logic [97:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= d[1:0];
    in_tdata <= d[97:2];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(d);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [10:0] rnd_coord(int span);
    case ($urandom_range(3))
      0: return 11'($urandom);
      default: return 11'($urandom_range(span + 8) - 4);
    endcase
  endfunction

  function automatic logic [97:0] rnd_cmd();
    int r;
    logic [10:0] lo, hi;
    r = $urandom_range(99);
    lo = ($urandom_range(3) == 0) ? 11'($urandom) : 11'($urandom_range(40) - 4);
    hi = ($urandom_range(3) == 0) ? 11'($urandom) : 11'($urandom_range(SW + 4, 60));
    if (r < 3)
      return pack_cmd(OP_CLEAR, 11'($urandom), 11'($urandom), 1'($urandom),
                      40'({$urandom, $urandom}), 1'($urandom), 11'($urandom),
                      11'($urandom), 3'($urandom));
    if (r < 40)
      return pack_cmd(OP_PIXEL, rnd_coord(SW), rnd_coord(SH), 1'($urandom),
                      40'({$urandom, $urandom}), 1'($urandom), 11'($urandom),
                      11'($urandom), 3'($urandom));
    if (r < 80)
      return pack_cmd(OP_GLYPH, rnd_coord(SW), rnd_coord(SH), 1'($urandom),
                      40'({$urandom, $urandom}), 1'($urandom), lo, hi, 3'($urandom));
    return pack_cmd(OP_REFRESH, 11'($urandom), 11'($urandom), 1'($urandom),
                    40'({$urandom, $urandom}), 1'($urandom), 11'($urandom),
                    11'($urandom), 3'($urandom));
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, clipping, cursor walk and wrap, highest page
    push_item(pack_cmd(OP_REFRESH, '0, '0, '0, '0, '0, '0, '0, 3'd0));
    push_item(pack_cmd(OP_PIXEL, 11'd0, 11'd0, 1'b1, '0, '0, '0, '0, '0));
    push_item(pack_cmd(OP_PIXEL, 11'd127, 11'd63, 1'b1, '0, '0, '0, '0, '0));
    push_item(pack_cmd(OP_PIXEL, 11'd128, 11'd5, 1'b1, '0, '0, '0, '0, '0));
    push_item(pack_cmd(OP_PIXEL, 11'h7FF, 11'd5, 1'b1, '0, '0, '0, '0, '0));
    push_item(pack_cmd(OP_PIXEL, 11'd5, 11'h400, 1'b1, '0, '0, '0, '0, '0));
    push_item(pack_cmd(OP_PIXEL, 11'h3FF, 11'h3FF, 1'b1, '1, 1'b1, '1, '1, '1));
    push_item(pack_cmd(OP_GLYPH, 11'd10, 11'd3, 1'b0, 40'hFF_FF_FF_FF_FF, 1'b0,
                       11'h400, 11'h3FF, 3'd0));
    push_item(pack_cmd(OP_GLYPH, '0, '0, 1'b0, 40'h12_34_56_78_9A, 1'b1,
                       11'd18, 11'd19, 3'd0));
    push_item(pack_cmd(OP_GLYPH, '0, '0, 1'b0, 40'hFF_FF_FF_FF_FF, 1'b1,
                       11'd30, 11'd20, 3'd0));
    push_item(pack_cmd(OP_GLYPH, 11'h7FE, 11'h7FC, 1'b0, 40'hFF_FF_FF_FF_FF, 1'b0,
                       11'h400, 11'h3FF, 3'd0));
    push_item(pack_cmd(OP_GLYPH, 11'd125, 11'd60, 1'b0, 40'hA5_A5_A5_A5_A5, 1'b0,
                       11'h400, 11'h3FF, 3'd0));
    push_item(pack_cmd(OP_PIXEL, 11'd12, 11'd4, 1'b0, '0, '0, '0, '0, '0));
    push_item(pack_cmd(OP_REFRESH, '0, '0, '0, '0, '0, '0, '0, 3'd0));
    push_item(pack_cmd(OP_REFRESH, '0, '0, '0, '0, '0, '0, '0, 3'd7));
    push_item(pack_cmd(OP_GLYPH, 11'h3FC, 11'd0, 1'b0, 40'h01, 1'b0,
                       11'h400, 11'h3FF, 3'd0));
    push_item(pack_cmd(OP_GLYPH, '0, '0, 1'b0, 40'h01, 1'b1, 11'h400, 11'h3FF, 3'd0));
    push_item(pack_cmd(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0));
    push_item(pack_cmd(OP_GLYPH, '0, '0, 1'b0, 40'h0F, 1'b1, 11'h400, 11'h3FF, 3'd0));
    push_item(pack_cmd(OP_REFRESH, '0, '0, '0, '0, '0, '0, '0, 3'd0));
    drain();
    // random phases with varied idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < 25; n++) push_item(rnd_cmd());
      drain();
    end
    // long receiver hold-off while refreshes keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk);
        hold_recv = 1'b0;
      end
      begin
        for (int n = 0; n < 5; n++)
          push_item(pack_cmd(OP_REFRESH, '0, '0, '0, '0, '0, '0, '0, 3'($urandom)));
      end
    join
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("mono_oled_framebuffer_engine_test passed");
    else
      $display("mono_oled_framebuffer_engine_test failed");
    $finish;
  end
endmodule

[sim.f]
hdl/mofb_pkg.sv
hdl/mofb_front.sv
hdl/mofb_queue.sv
hdl/mofb_back.sv
hdl/mono_oled_framebuffer_engine.sv
test/mono_oled_framebuffer_engine_test.sv
